/* design/permutation_keyed_xor_cipher_assert.svh */
// Assertion macros for the checker file of the cipher block.
`ifndef PERMUTATION_KEYED_XOR_CIPHER_ASSERT_SVH
`define PERMUTATION_KEYED_XOR_CIPHER_ASSERT_SVH

// Clocked assertion, quiet while reset is applied.
`define PKXC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define PKXC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pkxc_pkg.sv */
// Package: widths, reset key and defaults of the keyed xor cipher.
package pkxc_pkg;
	localparam int BYTE_W      = 8;
	localparam int KEY_W       = 56;
	localparam int MAX_KEY_LEN = 8;
	localparam int SEL_W       = 3;
	localparam int KEY_LEN_DEF = 7;
	localparam logic [KEY_W-1:0] KEY_RESET = 56'h1328F9874798A8;
endpackage

/* design/pkxc_in_if.sv */
// Input channel interface: data byte and end-of-message marker.
interface pkxc_in_if;
	import pkxc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/pkxc_out_if.sv */
// Output channel interface: transformed byte and end-of-message marker.
interface pkxc_out_if;
	import pkxc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* design/permutation_keyed_xor_cipher.sv */
// Inside a block an accepted byte is looked up in the key RAM, then waits for the output register.
// At a block start the next permutation runs first: the pivot search compares, the pivot
// swap, the reversal swaps and one closing check; a message start adds the key load.
// One item at a time: a new byte is accepted only while the sequencer is idle.
// Reset (arst_n low, asynchronous): key register to its default, new message pending,
// block position zero, output empty; the working key RAM is loaded on the next message.
module permutation_keyed_xor_cipher #(
	parameter int KEY_LEN = pkxc_pkg::KEY_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pkxc_pkg::KEY_W-1:0] cfg_wdata,
	pkxc_in_if.sink                    byte_in,
	pkxc_out_if.source                 byte_out
);
	import pkxc_pkg::*;

	localparam int IDX_W = $clog2(KEY_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_LEN - 1);
	localparam logic [IDX_W-1:0] PIV_START = IDX_W'(KEY_LEN - 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_FIND_RD, ST_FIND_CMP, ST_J_RD, ST_J_CMP,
		ST_SW_RD, ST_SW_W1, ST_SW_W2, ST_REV, ST_LOOK, ST_OUT
	} state_t;

	state_t             state_q;
	logic [KEY_W-1:0]   cipher_key_q;
	logic [BYTE_W-1:0]  data_q;
	logic               last_q;
	logic               fresh_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   cnt_q;    // load index, pivot search index
	logic [IDX_W-1:0]   pivot_q;
	logic [IDX_W-1:0]   j_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   sa_q;
	logic [IDX_W-1:0]   sb_q;
	logic [BYTE_W-1:0]  tmp_q;
	logic               ov_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;

	// RAM ports
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [BYTE_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]   ram_ra;
	logic [IDX_W-1:0]   ram_rb;
	logic [BYTE_W-1:0]  rd_a;
	logic [BYTE_W-1:0]  rd_b;

	// key byte selection for the load sweep
	logic [MAX_KEY_LEN*BYTE_W-1:0] key_ext;
	logic [SEL_W-1:0]              key_sel;
	logic [BYTE_W-1:0]             load_byte;

	// shared compare unit
	logic cmp_lt;
	logic cmp_le;
	logic out_free;

	// Key byte k sits at byte offset KEY_LEN-1-k; bytes past the register read as zero.
	assign key_ext   = {(MAX_KEY_LEN*BYTE_W-KEY_W)'(0), cipher_key_q};
	assign key_sel   = SEL_W'(KEY_LEN - 1) - SEL_W'(cnt_q);
	assign load_byte = key_ext[key_sel*BYTE_W +: BYTE_W];

	assign cmp_lt = rd_a < rd_b;
	assign cmp_le = rd_a <= rd_b;

	// The output register takes a new result when empty or being drained.
	assign out_free = !ov_q || byte_out.ready;

	assign byte_in.ready     = (state_q == ST_IDLE);
	assign byte_out.valid    = ov_q;
	assign byte_out.out_byte = out_byte_q;
	assign byte_out.out_last = out_last_q;

	// Read addresses follow the sequencer step; the lookup address holds while the
	// result waits for the output register, so the read data stays put.
	always_comb begin
		ram_ra = pos_q;
		ram_rb = sb_q;
		case (state_q)
			ST_FIND_RD: begin
				ram_ra = cnt_q;
				ram_rb = cnt_q + IDX_W'(1);
			end
			ST_J_RD: begin
				ram_ra = j_q;
				ram_rb = pivot_q;
			end
			ST_SW_RD: begin
				ram_ra = sa_q;
				ram_rb = sb_q;
			end
			default: begin
				ram_ra = pos_q;
				ram_rb = sb_q;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sa_q;
		ram_wdata = rd_b;
		case (state_q)
			ST_LOAD: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = load_byte;
			end
			ST_SW_W1: begin
				ram_we    = 1'b1;
				ram_waddr = sa_q;
				ram_wdata = rd_b;
			end
			ST_SW_W2: begin
				ram_we    = 1'b1;
				ram_waddr = sb_q;
				ram_wdata = tmp_q;
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = sa_q;
				ram_wdata = rd_b;
			end
		endcase
	end

	pkxc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (KEY_LEN)
	) u_key_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.raddr_b (ram_rb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Configuration register: a new key takes effect at the next message start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= KEY_RESET;
		end else if (cfg_we) begin
			cipher_key_q <= cfg_wdata;
		end
	end

	// Sequencer: load, pivot search, successor search, swaps, reversal, lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fresh_q    <= 1'b1;
			pos_q      <= '0;
			ov_q       <= 1'b0;
			cnt_q      <= '0;
			pivot_q    <= '0;
			j_q        <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			sa_q       <= '0;
			sb_q       <= '0;
			tmp_q      <= '0;
			data_q     <= '0;
			last_q     <= 1'b0;
			out_byte_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// drop the held result once the sink takes it; ST_OUT reloads it itself
			if (ov_q && byte_out.ready && state_q != ST_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (byte_in.valid) begin
						data_q <= byte_in.data_byte;
						last_q <= byte_in.last_byte;
						if (fresh_q) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else if (pos_q == '0) begin
							cnt_q   <= PIV_START;
							state_q <= ST_FIND_RD;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOAD: begin
					if (cnt_q == LAST_IDX) begin
						fresh_q <= 1'b0;
						pos_q   <= '0;
						cnt_q   <= PIV_START;
						state_q <= ST_FIND_RD;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_CMP;
				end
				ST_FIND_CMP: begin
					if (cmp_lt) begin
						pivot_q <= cnt_q;
						j_q     <= LAST_IDX;
						state_q <= ST_J_RD;
					end else if (cnt_q == '0) begin
						// last permutation: reverse the whole key
						lo_q    <= '0;
						hi_q    <= LAST_IDX;
						state_q <= ST_REV;
					end else begin
						cnt_q   <= cnt_q - IDX_W'(1);
						state_q <= ST_FIND_RD;
					end
				end
				ST_J_RD: begin
					state_q <= ST_J_CMP;
				end
				ST_J_CMP: begin
					if ((j_q == pivot_q + IDX_W'(1)) || !cmp_le) begin
						sa_q    <= pivot_q;
						sb_q    <= j_q;
						lo_q    <= pivot_q + IDX_W'(1);
						hi_q    <= LAST_IDX;
						state_q <= ST_SW_RD;
					end else begin
						j_q     <= j_q - IDX_W'(1);
						state_q <= ST_J_RD;
					end
				end
				ST_SW_RD: begin
					state_q <= ST_SW_W1;
				end
				ST_SW_W1: begin
					tmp_q   <= rd_a;
					state_q <= ST_SW_W2;
				end
				ST_SW_W2: begin
					state_q <= ST_REV;
				end
				ST_REV: begin
					if (lo_q < hi_q) begin
						sa_q    <= lo_q;
						sb_q    <= hi_q;
						lo_q    <= lo_q + IDX_W'(1);
						hi_q    <= hi_q - IDX_W'(1);
						state_q <= ST_SW_RD;
					end else begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						ov_q       <= 1'b1;
						out_byte_q <= data_q ^ rd_a;
						out_last_q <= last_q;
						if (last_q) begin
							pos_q   <= '0;
							fresh_q <= 1'b1;
						end else if (pos_q == LAST_IDX) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
						state_q <= ST_IDLE;
					end else if (ov_q && byte_out.ready) begin
						ov_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* design/pkxc_ram.sv */
// Generic RAM: one write port, two registered read ports.
module pkxc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

/* design/pkxc_chk.sv */
// Port checker for the cipher block and its bind.
`include "permutation_keyed_xor_cipher_assert.svh"

module pkxc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	`PKXC_ASSERT_ALWAYS(a_empty_in_reset, !arst_n |-> !out_valid, "output valid during reset")
	`PKXC_ASSERT_CLK(a_busy_after_accept, in_acc |=> !in_ready, "ready right after an accepted item")
	`PKXC_ASSERT_CLK(a_no_instant_result, (in_acc && !out_valid) |=> !out_valid, "result appeared one cycle after accept")
	`PKXC_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)), "stalled result changed")
endmodule

bind permutation_keyed_xor_cipher pkxc_chk u_pkxc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_in.valid),
	.in_ready  (byte_in.ready),
	.out_valid (byte_out.valid),
	.out_ready (byte_out.ready),
	.out_byte  (byte_out.out_byte),
	.out_last  (byte_out.out_last)
);
